@@ hw/rtl/wr5_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wr5_pkg
// shared widths, constants and payload types of the weno5 face reconstruction
// ----------------------------------------------------------------------------
package wr5_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // three candidate stencils
  localparam int NL = 3;

  // six times a candidate value, and the stencil differences
  localparam int SQ_W   = DATA_WIDTH + 5;
  localparam int DIFF_W = DATA_WIDTH + 4;
  localparam int SIDE_W = NL * SQ_W;

  localparam int          EPS_W     = 32;
  localparam logic [31:0] EPS_RESET = 32'd1;

  // queue between front and back
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] cell_m2;
    logic signed [DATA_WIDTH-1:0] cell_m1;
    logic signed [DATA_WIDTH-1:0] cell_c;
    logic signed [DATA_WIDTH-1:0] cell_p1;
    logic signed [DATA_WIDTH-1:0] cell_p2;
  } cell_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] face_value;
    logic                         saturated;
  } face_t;

  // stencil terms handed from front to back
  typedef struct packed {
    logic [NL-1:0][SQ_W-1:0]   six_q;
    logic [NL-1:0][DIFF_W-1:0] d1;
    logic [NL-1:0][DIFF_W-1:0] d2;
  } sten_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hw/rtl/weno5_reconstruction.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weno5_reconstruction
// fifth-order upwind reconstruction at the right cell face, fixed point
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------
//   cell     | in        | cell_valid/stall   | five stencil values
//   face     | out       | face_valid/stall   | face value, saturated flag
//   config   | in        | wr_en              | wr_data -> epsilon
//
// one request accepted per cycle while the queue is not full; the back
// pipeline holds the two restoring dividers (61 and 32 quotient bits, one
// bit per stage)
// synchronous reset clears all valids and loads epsilon with one
// a face stall on a valid result freezes the back pipeline; the queue and
// the front register keep taking requests until the queue fills
// ----------------------------------------------------------------------------
module weno5_reconstruction #(
  parameter int FRAC_BITS = wr5_pkg::FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cell_valid,
  output logic           cell_stall,
  input  wr5_pkg::cell_t stencil,
  output logic           face_valid,
  input  logic           face_stall,
  output wr5_pkg::face_t face,
  input  logic           wr_en,
  input  logic [31:0]    wr_data
);

  localparam int DW = wr5_pkg::DATA_WIDTH;
  localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

  // epsilon register, scale of a squared smoothness value
  logic [31:0] eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= wr5_pkg::EPS_RESET;
    end else if (wr_en) begin
      eps <= wr_data;
    end
  end

  // front: stencil terms, queue, back: the arithmetic
  wr5_pkg::q_stat_t qs;
  wr5_pkg::sten_t   item, head;
  logic             push, pop;

  wr5_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .stencil    (stencil),
    .cell_stall (cell_stall),
    .qs         (qs),
    .push       (push),
    .item       (item)
  );

  wr5_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item),
    .pop   (pop),
    .rdata (head),
    .qs    (qs)
  );

  wr5_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .eps        (eps),
    .head       (head),
    .qs         (qs),
    .pop        (pop),
    .face_stall (face_stall),
    .face_valid (face_valid),
    .face       (face)
  );

  // a clipped result sits at one of the signed extremes
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    face_valid && face.saturated |->
      (face.face_value == MAX_V) || (face.face_value == MIN_V))
    else $error("saturated result not at a range limit");

  // queue status is consistent
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(qs.full && qs.empty))
    else $error("queue full and empty at once");

  // a request held at the front is pushed or still held next cycle
  a_front_kept: assert property (@(posedge clk) disable iff (rst)
    cell_stall |=> push || cell_stall)
    else $error("held request dropped at the front");

endmodule

@@ hw/rtl/wr5_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wr5_front
// request intake: forms candidate values and stencil differences
// ----------------------------------------------------------------------------
module wr5_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cell_valid,
  input  wr5_pkg::cell_t   stencil,
  output logic             cell_stall,
  input  wr5_pkg::q_stat_t qs,
  output logic             push,
  output wr5_pkg::sten_t   item
);

  localparam int SQ_W   = wr5_pkg::SQ_W;
  localparam int DIFF_W = wr5_pkg::DIFF_W;

  logic signed [SQ_W-1:0] m2, m1, c, p1, p2;
  wr5_pkg::sten_t         terms;
  logic                   fr_valid;

  always_comb begin
    m2 = SQ_W'($signed(stencil.cell_m2));
    m1 = SQ_W'($signed(stencil.cell_m1));
    c  = SQ_W'($signed(stencil.cell_c));
    p1 = SQ_W'($signed(stencil.cell_p1));
    p2 = SQ_W'($signed(stencil.cell_p2));

    terms.six_q[0] = (c <<< 1) + (p1 <<< 2) + p1 - p2;
    terms.six_q[1] = (c <<< 2) + c + (p1 <<< 1) - m1;
    terms.six_q[2] = (m2 <<< 1) - (m1 <<< 3) + m1 + (c <<< 3) + (c <<< 1) + c;

    terms.d1[0] = DIFF_W'(c - (p1 <<< 1) + p2);
    terms.d2[0] = DIFF_W'((c <<< 1) + c - (p1 <<< 2) + p2);
    terms.d1[1] = DIFF_W'(m1 - (c <<< 1) + p1);
    terms.d2[1] = DIFF_W'(m1 - p1);
    terms.d1[2] = DIFF_W'(m2 - (m1 <<< 1) + c);
    terms.d2[2] = DIFF_W'(m2 - (m1 <<< 2) + (c <<< 1) + c);
  end

  // hold while the queue is full
  assign cell_stall = fr_valid && qs.full;
  assign push       = fr_valid && !qs.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (!cell_stall) begin
      fr_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cell_stall && cell_valid) begin
      item <= terms;
    end
  end

endmodule

@@ hw/rtl/wr5_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wr5_fifo
// short queue of stencil terms between front and back
// ----------------------------------------------------------------------------
module wr5_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wr5_pkg::sten_t   wdata,
  input  logic             pop,
  output wr5_pkg::sten_t   rdata,
  output wr5_pkg::q_stat_t qs
);

  localparam int DEPTH = wr5_pkg::QDEPTH;
  localparam int AW    = $clog2(DEPTH);

  wr5_pkg::sten_t mem [DEPTH];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    cnt;

  assign qs.full  = (cnt == (AW+1)'(DEPTH));
  assign qs.empty = (cnt == '0);
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

@@ hw/rtl/wr5_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wr5_div
// pipelined restoring divider, one quotient bit per stage, three lanes
// ----------------------------------------------------------------------------
module wr5_div #(
  parameter int XW = 61,
  parameter int YW = 64,
  parameter int QW = 61,
  parameter int SW = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [wr5_pkg::NL-1:0][XW-1:0] x,
  input  logic [wr5_pkg::NL-1:0][YW-1:0] y,
  input  logic [SW-1:0]                 side_in,
  output logic                          out_valid,
  output logic [wr5_pkg::NL-1:0][QW-1:0] q,
  output logic [SW-1:0]                 side_out
);

  localparam int NL = wr5_pkg::NL;

  logic [YW-1:0] rm   [QW+1][NL];
  logic [QW-1:0] xl   [QW+1][NL];
  logic [QW-1:0] qq   [QW+1][NL];
  logic [YW-1:0] dv   [QW+1][NL];
  logic [SW-1:0] sd   [QW+1];
  logic [QW:0]   vv;
  logic [YW-1:0] rm_n [QW][NL];
  logic [QW-1:0] qq_n [QW][NL];

  always_comb begin
    logic [YW:0] tr;
    logic        ge;
    for (int s = 0; s < QW; s++) begin
      for (int k = 0; k < NL; k++) begin
        tr = {rm[s][k], xl[s][k][QW-1-s]};
        ge = (tr >= {1'b0, dv[s][k]});
        rm_n[s][k] = ge ? YW'(tr - {1'b0, dv[s][k]}) : YW'(tr);
        qq_n[s][k] = {qq[s][k][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      for (int k = 0; k < NL; k++) begin
        rm[0][k] <= YW'(x[k] >> QW);
        xl[0][k] <= x[k][QW-1:0];
        qq[0][k] <= '0;
        dv[0][k] <= y[k];
      end
      for (int s = 0; s < QW; s++) begin
        sd[s+1] <= sd[s];
        for (int k = 0; k < NL; k++) begin
          rm[s+1][k] <= rm_n[s][k];
          xl[s+1][k] <= xl[s][k];
          qq[s+1][k] <= qq_n[s][k];
          dv[s+1][k] <= dv[s][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= '0;
    end else if (en) begin
      vv <= {vv[QW-1:0], in_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      q[k] = qq[QW][k];
    end
  end

  assign out_valid = vv[QW];
  assign side_out  = sd[QW];

endmodule

@@ hw/rtl/wr5_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wr5_back
// smoothness, weights and weighted sum: the execution pipeline
// ----------------------------------------------------------------------------
module wr5_back #(
  parameter int FRAC_BITS = wr5_pkg::FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      eps,
  input  wr5_pkg::sten_t   head,
  input  wr5_pkg::q_stat_t qs,
  output logic             pop,
  input  logic             face_stall,
  output logic             face_valid,
  output wr5_pkg::face_t   face
);

  localparam int NL     = wr5_pkg::NL;
  localparam int DW     = wr5_pkg::DATA_WIDTH;
  localparam int SQ_W   = wr5_pkg::SQ_W;
  localparam int DIFF_W = wr5_pkg::DIFF_W;
  localparam int SIDE_W = wr5_pkg::SIDE_W;
  localparam int PRE    = 12;
  localparam int POST   = 5;
  localparam int MUL    = 3;
  localparam int MAG_W  = 30;
  localparam int R_W    = 61;
  localparam int A_W    = 63;
  localparam int AK_W   = 31;
  localparam int Y2_W   = 34;
  localparam int W_W    = 32;
  localparam int DNORM  = 30;
  localparam int TNORM  = 31;

  localparam logic [MAG_W-1:0] MAG_MAX  = '1;
  localparam logic [63:0]      BETA_LIM = 64'h3_0000_0000;
  localparam logic [31:0]      RECIP3   = 32'hAAAA_AAAB;
  localparam logic [R_W-1:0]   NUM1     = R_W'(1) << 60;
  localparam logic [65:0]      HALF     = 66'h8000_0000;

  function automatic logic [MAG_W-1:0] clip_mag(input logic [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] m;
    m = d[DIFF_W-1] ? (~d + 1'b1) : d;
    return (m > DIFF_W'(MAG_MAX)) ? MAG_MAX : m[MAG_W-1:0];
  endfunction

  function automatic logic [2:0] msb8(input logic [7:0] b);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = 3'(i);
    end
    return p;
  endfunction

  // bit length from per-byte flags and msb positions
  function automatic logic [6:0] top_len(input logic [7:0] nz, input logic [7:0][2:0] pos);
    logic [6:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      if (nz[j]) r = 7'(j * 8) + 7'(pos[j]) + 7'd1;
    end
    return r;
  endfunction

  logic adv;
  assign adv = !face_valid || !face_stall;
  assign pop = adv && !qs.empty;

  // valid and candidate values ride along the pre-divide stages
  logic [PRE-1:0]    vp;
  logic [SIDE_W-1:0] sp [PRE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (adv) begin
      vp <= {vp[PRE-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp[0] <= head.six_q;
      for (int n = 1; n < PRE; n++) begin
        sp[n] <= sp[n-1];
      end
    end
  end

  logic [MAG_W-1:0] mag1 [NL], mag2 [NL];
  logic [59:0]      sqa  [NL], sqb  [NL];
  logic [63:0]      tt   [NL], ut   [NL];
  logic [31:0]      uh4  [NL], uh5  [NL];
  logic [1:0]       ul4  [NL], ul5  [NL];
  logic             bs4  [NL], bs5  [NL];
  logic [63:0]      pr   [NL];
  logic [29:0]      q05  [NL];
  logic [1:0]       rr   [NL], fq   [NL];
  logic [31:0]      beta6 [NL];
  logic [63:0]      bsq7 [NL];
  logic [64:0]      dsum [NL];
  logic [63:0]      den8 [NL], den9 [NL], den10 [NL], den11 [NL];
  logic [63:0]      dmin9;
  logic [7:0]       nz10;
  logic [7:0][2:0]  pos10;
  logic [6:0]       len1;
  logic [5:0]       sh_n, sh11;
  logic [63:0]      dq   [NL];
  logic [NL-1:0][63:0] dd12;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      ut[k]   = tt[k] >> (FRAC_BITS + 2);
      pr[k]   = 64'(uh4[k]) * 64'(RECIP3);
      rr[k]   = 2'(uh5[k] - 32'({q05[k], 1'b0}) - 32'(q05[k]));
      dsum[k] = {1'b0, bsq7[k]} + 65'(eps);
      dq[k]   = den11[k] >> sh11;
      case ({rr[k], ul5[k]})
        4'd0, 4'd1, 4'd2:    fq[k] = 2'd0;
        4'd3, 4'd4, 4'd5:    fq[k] = 2'd1;
        4'd6, 4'd7, 4'd8:    fq[k] = 2'd2;
        4'd9, 4'd10, 4'd11:  fq[k] = 2'd3;
        default:             fq[k] = 2'd0;
      endcase
    end
    len1 = top_len(nz10, pos10);
    sh_n = (len1 > 7'(DNORM)) ? 6'(len1 - 7'(DNORM)) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NL; k++) begin
        mag1[k]  <= clip_mag(head.d1[k]);
        mag2[k]  <= clip_mag(head.d2[k]);
        sqa[k]   <= 60'(mag1[k]) * 60'(mag1[k]);
        sqb[k]   <= 60'(mag2[k]) * 60'(mag2[k]);
        tt[k]    <= 64'({sqa[k], 3'b000}) + 64'({sqa[k], 2'b00}) + 64'(sqa[k])
                  + 64'({sqb[k], 1'b0}) + 64'(sqb[k]);
        // floor(t/12) >> frac, split as a divide by three
        bs4[k]   <= (ut[k] >= BETA_LIM);
        uh4[k]   <= ut[k][33:2];
        ul4[k]   <= ut[k][1:0];
        q05[k]   <= pr[k][62:33];
        uh5[k]   <= uh4[k];
        ul5[k]   <= ul4[k];
        bs5[k]   <= bs4[k];
        beta6[k] <= bs5[k] ? '1 : {q05[k], 2'b00} + 32'(fq[k]);
        bsq7[k]  <= 64'(beta6[k]) * 64'(beta6[k]);
        den8[k]  <= dsum[k][64] ? '1 : ((dsum[k][63:0] == '0) ? 64'd1 : dsum[k][63:0]);
        den9[k]  <= den8[k];
        den10[k] <= den9[k];
        den11[k] <= den10[k];
        dd12[k]  <= (dq[k] == '0) ? 64'd1 : dq[k];
      end
      dmin9 <= (den8[1] < den8[0]) ? ((den8[2] < den8[1]) ? den8[2] : den8[1])
                                   : ((den8[2] < den8[0]) ? den8[2] : den8[0]);
      for (int j = 0; j < 8; j++) begin
        nz10[j]  <= |dmin9[8*j +: 8];
        pos10[j] <= msb8(dmin9[8*j +: 8]);
      end
      sh11 <= sh_n;
    end
  end

  // reciprocal 2^60 / d per stencil
  logic [NL-1:0][R_W-1:0] r1;
  logic                   v_r1;
  logic [SIDE_W-1:0]      s_r1;

  wr5_div #(.XW(R_W), .YW(64), .QW(R_W), .SW(SIDE_W)) u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vp[PRE-1]),
    .x         ({NL{NUM1}}),
    .y         (dd12),
    .side_in   (sp[PRE-1]),
    .out_valid (v_r1),
    .q         (r1),
    .side_out  (s_r1)
  );

  logic [POST-1:0]   vq;
  logic [SIDE_W-1:0] sq_l [POST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (adv) begin
      vq <= {vq[POST-2:0], v_r1};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_l[0] <= s_r1;
      for (int n = 1; n < POST; n++) begin
        sq_l[n] <= sq_l[n-1];
      end
    end
  end

  logic [A_W-1:0]  a1 [NL], a2 [NL], a3 [NL], a4 [NL];
  logic [63:0]     tot2, tot3, tot4;
  logic [7:0]      nz3;
  logic [7:0][2:0] pos3;
  logic [6:0]      len2;
  logic [5:0]      sh2_n, sh4;
  logic [AK_W-1:0] tn, tz;
  logic [NL-1:0][AK_W-1:0] ak5;
  logic [NL-1:0][Y2_W-1:0] y5;
  logic [NL-1:0][A_W-1:0]  x2;

  always_comb begin
    len2  = top_len(nz3, pos3);
    sh2_n = (len2 > 7'(TNORM)) ? 6'(len2 - 7'(TNORM)) : 6'd0;
    tn    = AK_W'(tot4 >> sh4);
    tz    = (tn == '0) ? AK_W'(1) : tn;
    for (int k = 0; k < NL; k++) begin
      x2[k] = {ak5[k], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // linear weights 3, 6, 1
      a1[0] <= A_W'({r1[0], 1'b0}) + A_W'(r1[0]);
      a1[1] <= A_W'({r1[1], 2'b00}) + A_W'({r1[1], 1'b0});
      a1[2] <= A_W'(r1[2]);
      tot2  <= 64'(a1[0]) + 64'(a1[1]) + 64'(a1[2]);
      for (int k = 0; k < NL; k++) begin
        a2[k]  <= a1[k];
        a3[k]  <= a2[k];
        a4[k]  <= a3[k];
        ak5[k] <= AK_W'(a4[k] >> sh4);
        y5[k]  <= Y2_W'({tz, 2'b00}) + Y2_W'({tz, 1'b0});
      end
      tot3 <= tot2;
      tot4 <= tot3;
      for (int j = 0; j < 8; j++) begin
        nz3[j]  <= |tot2[8*j +: 8];
        pos3[j] <= msb8(tot2[8*j +: 8]);
      end
      sh4 <= sh2_n;
    end
  end

  // normalized weights a*2^32 / (6*total)
  logic [NL-1:0][W_W-1:0] w2;
  logic                   v_w;
  logic [SIDE_W-1:0]      s_w;

  wr5_div #(.XW(A_W), .YW(Y2_W), .QW(W_W), .SW(SIDE_W)) u_weight (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vq[POST-1]),
    .x         (x2),
    .y         (y5),
    .side_in   (sq_l[POST-1]),
    .out_valid (v_w),
    .q         (w2),
    .side_out  (s_w)
  );

  logic [MUL-1:0]     vm;
  logic [63:0]        ext  [NL];
  logic [63:0]        plo1 [NL];
  logic signed [64:0] phi1 [NL];
  logic [65:0]        slo2;
  logic signed [66:0] shi2;
  logic [67:0]        res3;
  logic               over, under;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      ext[k] = 64'($signed(s_w[k*SQ_W +: SQ_W]));
    end
    over  = !res3[67] && (res3[66:DW-1] != '0);
    under = res3[67] && (res3[66:DW-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= '0;
    end else if (adv) begin
      vm <= {vm[MUL-2:0], v_w};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NL; k++) begin
        plo1[k] <= 64'(w2[k]) * 64'(ext[k][31:0]);
        phi1[k] <= 65'($signed({1'b0, w2[k]})) * 65'($signed(ext[k][63:32]));
      end
      slo2 <= 66'(plo1[0]) + 66'(plo1[1]) + 66'(plo1[2]) + HALF;
      shi2 <= 67'(phi1[0]) + 67'(phi1[1]) + 67'(phi1[2]);
      res3 <= 68'(shi2) + 68'({1'b0, slo2[65:32]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_valid <= 1'b0;
    end else if (adv) begin
      face_valid <= vm[MUL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vm[MUL-1]) begin
      face.saturated <= over || under;
      if (over) begin
        face.face_value <= {1'b0, {(DW-1){1'b1}}};
      end else if (under) begin
        face.face_value <= {1'b1, {(DW-1){1'b0}}};
      end else begin
        face.face_value <= res3[DW-1:0];
      end
    end
  end

endmodule

@@ sim/tb_weno5_reconstruction.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weno5_reconstruction
// self-checking bench for the fifth-order face reconstruction
// random gaps on the cell channel, random stalls on the face channel,
// in-order check of every result, epsilon changed only once drained
// ----------------------------------------------------------------------------
module tb_weno5_reconstruction;

  localparam int CLK_HALF   = 4;
  localparam int DRAIN_WAIT = 160;   // margin after the scoreboard empties
  localparam int WDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 230;

  // scoreboard: predicts face values and holds them until they come out
  class face_board;
    wr5_pkg::face_t face_q[$];
    logic [31:0]    eps;
    int             errors;

    function new();
      eps    = wr5_pkg::EPS_RESET;
      errors = 0;
    endfunction

    // smoothness term plus epsilon, as one weight denominator
    function logic [63:0] smooth_den(longint d1, longint d2);
      logic [63:0] m1, m2, t, b;
      logic [64:0] s;
      m1 = (d1 < 0) ? -d1 : d1;
      m2 = (d2 < 0) ? -d2 : d2;
      if (m1 > 64'h3FFFFFFF) m1 = 64'h3FFFFFFF;
      if (m2 > 64'h3FFFFFFF) m2 = 64'h3FFFFFFF;
      t = 64'd13 * m1 * m1 + 64'd3 * m2 * m2;
      b = (t / 64'd12) >> wr5_pkg::FRAC_BITS;
      if (b > 64'hFFFFFFFF) b = 64'hFFFFFFFF;
      s = 65'(b * b) + 65'(eps);
      if (s[64]) return '1;
      if (s == 0) return 64'd1;   // flat stencil with zero epsilon
      return s[63:0];
    endfunction

    function wr5_pkg::face_t predict(wr5_pkg::cell_t c);
      longint                m2, m1, cc, p1, p2, res;
      logic signed [63:0]    sq[3];
      logic [63:0]           den[3], a[3];
      logic [63:0]           dmin, total, d, ak, w, lin;
      logic signed [127:0]   acc, wk, sx;
      int                    sh;
      wr5_pkg::face_t        f;
      m2 = $signed(c.cell_m2);
      m1 = $signed(c.cell_m1);
      cc = $signed(c.cell_c);
      p1 = $signed(c.cell_p1);
      p2 = $signed(c.cell_p2);
      sq[0] = 2 * cc + 5 * p1 - p2;
      sq[1] = -m1 + 5 * cc + 2 * p1;
      sq[2] = 2 * m2 - 7 * m1 + 11 * cc;
      den[0] = smooth_den(cc - 2 * p1 + p2, 3 * cc - 4 * p1 + p2);
      den[1] = smooth_den(m1 - 2 * cc + p1, m1 - p1);
      den[2] = smooth_den(m2 - 2 * m1 + cc, m2 - 4 * m1 + 3 * cc);
      dmin = den[0];
      if (den[1] < dmin) dmin = den[1];
      if (den[2] < dmin) dmin = den[2];
      sh = 0;
      while ((dmin >> sh) >= (64'd1 << 30)) sh++;
      total = 0;
      for (int k = 0; k < 3; k++) begin
        d = den[k] >> sh;
        if (d == 0) d = 64'd1;
        lin = (k == 0) ? 64'd3 : (k == 1) ? 64'd6 : 64'd1;
        a[k] = lin * ((64'd1 << 60) / d);
        total += a[k];
      end
      sh = 0;
      while ((total >> sh) >= (64'd1 << 31)) sh++;
      total = total >> sh;
      if (total == 0) total = 64'd1;
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        ak  = a[k] >> sh;
        w   = (ak << 32) / (64'd6 * total);
        wk  = $signed({64'd0, w});
        sx  = sq[k];
        acc = acc + wk * sx;
      end
      // round half up, then back to Q16.16
      acc = acc + 128'sh80000000;
      res = longint'(acc >>> 32);
      f.saturated = 1'b0;
      if (res > 64'sh7FFFFFFF) begin
        res = 64'sh7FFFFFFF;
        f.saturated = 1'b1;
      end
      if (res < -64'sh80000000) begin
        res = -64'sh80000000;
        f.saturated = 1'b1;
      end
      f.face_value = res[31:0];
      return f;
    endfunction

    function void note_cell(wr5_pkg::cell_t c);
      face_q.push_back(predict(c));
    endfunction

    function void check_face(wr5_pkg::face_t got);
      wr5_pkg::face_t want;
      if (face_q.size() == 0) begin
        $display("%0t: face result with nothing pending: value %h sat %b",
                 $time, got.face_value, got.saturated);
        errors++;
        return;
      end
      want = face_q.pop_front();
      if (got.face_value !== want.face_value) begin
        $display("%0t: face_value expected %h actual %h",
                 $time, want.face_value, got.face_value);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b",
                 $time, want.saturated, got.saturated);
        errors++;
      end
    endfunction

    function int pending();
      return face_q.size();
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst;
  logic           cell_valid;
  logic           cell_stall;
  wr5_pkg::cell_t stencil;
  logic           face_valid;
  logic           face_stall;
  wr5_pkg::face_t face;
  logic           wr_en;
  logic [31:0]    wr_data;

  face_board board = new();
  bit        calm;        // when set neither side idles
  int        quiet_cycles;

  always #(CLK_HALF) clk = ~clk;

  weno5_reconstruction u_dut (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .stencil    (stencil),
    .face_valid (face_valid),
    .face_stall (face_stall),
    .face       (face),
    .wr_en      (wr_en),
    .wr_data    (wr_data)
  );

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // one request on the cell channel; valid stays up across back-to-back items
  task automatic send_cell(wr5_pkg::cell_t c);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_valid <= 1'b1;
    stencil    <= c;
    do @(posedge clk); while (cell_stall);
    board.note_cell(c);
  endtask

  // epsilon may only change once the pipeline is empty
  task automatic set_epsilon(logic [31:0] v);
    cell_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en   <= 1'b0;
    board.eps = v;
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 6))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return 32'h00000000;
      3:       return 32'hFFFFFFFF;
      4:       return 32'h00010000;
      default: return $urandom;
    endcase
  endfunction

  // random stencils of several shapes: smooth, noisy, steps and extremes
  function automatic wr5_pkg::cell_t rand_cell();
    wr5_pkg::cell_t c;
    logic [31:0]    v[5];
    logic [31:0]    base, lvl2;
    int             slope, pos, shr;
    case ($urandom_range(0, 5))
      0: foreach (v[i]) v[i] = $urandom;
      1: begin
        base  = $urandom;
        slope = $signed($urandom) >>> $urandom_range(4, 31);
        foreach (v[i]) v[i] = base + slope * i;
      end
      2: begin
        shr = $urandom_range(0, 31);
        foreach (v[i]) v[i] = $signed($urandom) >>> shr;
      end
      3: begin
        base = $signed($urandom) >>> $urandom_range(0, 20);
        lvl2 = $signed($urandom) >>> $urandom_range(0, 20);
        pos  = $urandom_range(0, 5);
        foreach (v[i]) v[i] = (i < pos) ? base : lvl2;
      end
      4: foreach (v[i]) v[i] = pick_level();
      default: begin
        base = $signed($urandom) >>> $urandom_range(8, 31);
        foreach (v[i]) v[i] = base + ($signed($urandom) >>> $urandom_range(12, 31));
      end
    endcase
    c = {v[0], v[1], v[2], v[3], v[4]};
    return c;
  endfunction

  function automatic wr5_pkg::cell_t mk(logic [31:0] a, b, cc, d, e);
    wr5_pkg::cell_t c;
    c = {a, b, cc, d, e};
    return c;
  endfunction

  // flat and constant stencils hit the zero-smoothness path under each epsilon
  task automatic send_flat();
    send_cell(mk(0, 0, 0, 0, 0));
    send_cell(mk(32'h00030000, 32'h00030000, 32'h00030000, 32'h00030000,
                 32'h00030000));
  endtask

  // face channel: random stall before each result
  initial begin
    int n;
    face_stall = 1'b1;
    @(negedge rst);
    forever begin
      n = idle_draw();
      if (n > 0) begin
        face_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      face_stall <= 1'b0;
      do @(posedge clk); while (!face_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && face_valid && !face_stall) board.check_face(face);
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (cell_valid && !cell_stall) || (face_valid && !face_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] eps_plan[6];
    rst        = 1'b1;
    cell_valid = 1'b0;
    stencil    = '0;
    wr_en      = 1'b0;
    wr_data    = '0;
    calm       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, flat, ramps, isolated spikes, saturating stencils
    send_flat();
    send_cell(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF));
    send_cell(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000));
    send_cell(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'h80000000));
    send_cell(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h7FFFFFFF));
    send_cell(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h80000000));
    send_cell(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7FFFFFFF));
    send_cell(mk(0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
    send_cell(mk(0, 0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
    send_cell(mk(32'hFFFE0000, 32'hFFFF0000, 0, 32'h00010000, 32'h00020000));
    send_cell(mk(32'h00040000, 32'h00010000, 0, 32'h00010000, 32'h00040000));
    for (int i = 0; i < 5; i++) begin
      logic [31:0] v[5];
      foreach (v[j]) v[j] = (i == j) ? 32'h00100000 : 32'h0;
      send_cell(mk(v[0], v[1], v[2], v[3], v[4]));
    end
    send_cell(mk(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_cell(mk(32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 32'h00000001,
                 32'hFFFFFFFF));
    send_cell(mk(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                 32'h55555555));

    // zero, largest, reset value and random epsilon settings
    eps_plan[0] = 32'h00000001;
    eps_plan[1] = 32'h00000000;
    eps_plan[2] = 32'hFFFFFFFF;
    eps_plan[3] = $urandom;
    eps_plan[4] = 32'h00010000;
    eps_plan[5] = $urandom_range(1, 255);
    foreach (eps_plan[p]) begin
      if (p > 0) begin
        set_epsilon(eps_plan[p]);
        send_flat();
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
        send_cell(rand_cell());
      end
      calm = 1'b0;
    end

    cell_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
